/* sv/sitd_pkg.sv */
// Shared types, constants and helper functions for the signed integer to
// decimal ASCII unit. No dependencies.
package sitd_pkg;

    localparam int SITD_VALUE_BITS = 64;
    localparam int SITD_IN_BITS    = 64;
    localparam int SITD_CHAR_BITS  = 6;

    localparam logic [SITD_CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [SITD_CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

    // Decimal digits in 2**(bits-1), the largest magnitude.
    function automatic int sitd_digits(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_DONE
    } cv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_DIGIT
    } em_state_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } cv_status_t;

endpackage

/* sv/sitd_conv.sv */
// Bit-serial binary to BCD converter (shift-and-add-3).
// Depends on sitd_pkg.
module sitd_conv #(
    parameter int VALUE_BITS = sitd_pkg::SITD_VALUE_BITS,
    parameter int NUM_DIGITS = sitd_pkg::sitd_digits(sitd_pkg::SITD_VALUE_BITS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sitd_pkg::SITD_IN_BITS-1:0]   in_value,
    output sitd_pkg::cv_status_t                status,
    output logic [4*NUM_DIGITS-1:0]             bcd,
    input  logic                                take
);
    import sitd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int BCD_W = 4 * NUM_DIGITS;

    cv_state_t               state_reg, state_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]   x;
    logic [BCD_W-1:0]        adj;

    assign x = in_value[VALUE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = x[VALUE_BITS-1];
                    mag_next   = x[VALUE_BITS-1] ? (~x + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : x;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_BITS);
                    state_next = CV_SHIFT;
                end
            end
            CV_SHIFT:
            begin
                bcd_next = {adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (take)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    assign in_ready     = (state_reg == CV_IDLE);
    assign status.valid = (state_reg == CV_DONE);
    assign status.neg   = neg_reg;
    assign bcd          = bcd_reg;

endmodule

/* sv/sitd_emit.sv */
// Character emitter: drops leading zero digits, sends sign and digits one
// item per cycle if unstalled, via output register. Depends on sitd_pkg.
module sitd_emit #(
    parameter int NUM_DIGITS = sitd_pkg::sitd_digits(sitd_pkg::SITD_VALUE_BITS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sitd_pkg::cv_status_t                status,
    input  logic [4*NUM_DIGITS-1:0]             bcd,
    output logic                                take,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sitd_pkg::SITD_CHAR_BITS-1:0] out_char,
    output logic                                out_last
);
    import sitd_pkg::*;

    localparam int REM_W = $clog2(NUM_DIGITS + 1);
    localparam int BCD_W = 4 * NUM_DIGITS;

    em_state_t                 state_reg, state_next;
    logic [BCD_W-1:0]          digits_reg, digits_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic                      started_reg, started_next;
    logic                      valid_reg, valid_next;
    logic [SITD_CHAR_BITS-1:0] char_reg, char_next;
    logic                      last_reg, last_next;
    logic                      slot_free;
    logic                      emit;
    logic                      final_digit;
    logic [3:0]                top;

    assign slot_free   = !valid_reg || out_ready;
    assign top         = digits_reg[BCD_W-1 -: 4];
    assign final_digit = (rem_reg == REM_W'(1));
    assign take        = status.valid && (state_reg == EM_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= EM_IDLE;
            rem_reg     <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        digits_next  = digits_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        emit         = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (status.valid)
                begin
                    digits_next  = bcd;
                    rem_next     = REM_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = status.neg ? EM_SIGN : EM_DIGIT;
                end
            end
            EM_SIGN:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT:
            begin
                if (!started_reg && top == 4'd0 && !final_digit)
                begin
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    rem_next    = rem_reg - REM_W'(1);
                end
                else if (slot_free)
                begin
                    emit         = 1'b1;
                    char_next    = CHAR_ZERO + {2'b00, top};
                    last_next    = final_digit;
                    digits_next  = {digits_reg[BCD_W-5:0], 4'd0};
                    rem_next     = rem_reg - REM_W'(1);
                    started_next = 1'b1;
                    if (final_digit)
                    begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

/* sv/signed_int_to_decimal_ascii_unit.sv */
// Top level of the signed integer to decimal ASCII unit.
// Depends on sitd_pkg, sitd_conv and sitd_emit.
//
//   channel   direction  tdata                          tuser  tlast
//   s_axis    in         [63:0] value                   -      -
//   m_axis    out        [5:0] char_code, [7:6] zero    -      last_char
//
// Conversion loads the value, then runs the shift-and-add-3 loop once per
// value bit; emission walks each BCD digit position in turn, after a minus
// sign for a negative value, skipping leading zeros.
// Conversion of the next item overlaps emission of the current one, so a new
// value can be accepted before the last one's characters are all sent.
// rst_n clears all control state asynchronously.
// A stalled m_axis holds the current character; s_axis stalls until done.
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sitd_pkg::SITD_VALUE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sitd_pkg::SITD_IN_BITS-1:0] s_axis_tdata,   // [63:0] value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [5:0] char_code
    output logic                              m_axis_tlast
);
    import sitd_pkg::*;

    localparam int NUM_DIGITS = sitd_digits(VALUE_BITS);

    cv_status_t                cv_status;
    logic [4*NUM_DIGITS-1:0]   cv_bcd;
    logic                      cv_take;
    logic [SITD_CHAR_BITS-1:0] out_char;

    sitd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata),
        .status   (cv_status),
        .bcd      (cv_bcd),
        .take     (cv_take)
    );

    sitd_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (cv_status),
        .bcd       (cv_bcd),
        .take      (cv_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_char};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while conversion in progress");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == CHAR_MINUS |-> !m_axis_tlast)
        else $error("minus sign flagged as last character");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] == CHAR_MINUS) ||
            (m_axis_tdata[5:0] >= CHAR_ZERO && m_axis_tdata[5:0] <= CHAR_ZERO + 6'd9))
        else $error("character code out of range");

    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[5:0] == CHAR_MINUS |=>
            !(m_axis_tvalid && m_axis_tdata[5:0] == CHAR_MINUS))
        else $error("two minus signs in a row");
`endif

endmodule

/* tb/sv/sitd_tb_pkg.sv */
`timescale 1ns / 1ps
// Expected-text store and checker for the signed integer to decimal ASCII unit.
// Depends on sitd_pkg for the character codes.
package sitd_tb_pkg;

    import sitd_pkg::*;

    typedef struct packed {
        logic [SITD_CHAR_BITS-1:0] code;
        logic                      last;
    } ascii_char_t;

    class decimal_text_checker;

        ascii_char_t pending_chars[$];
        int          mismatches = 0;

        function void add_value(input logic [SITD_IN_BITS-1:0] value);
            logic [63:0] mag;
            logic [63:0] rem;
            logic [3:0]  digs[20];
            logic        neg;
            int          nd;
            int          i;
            neg = value[63];
            mag = neg ? (~value + 64'd1) : value;
            nd  = 0;
            do
            begin
                rem      = mag % 64'd10;
                digs[nd] = rem[3:0];
                mag      = mag / 64'd10;
                nd++;
            end
            while (mag != 64'd0 && nd < 19);
            if (neg)
                pending_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
            for (i = nd - 1; i >= 0; i--)
                pending_chars.push_back('{code: CHAR_ZERO + SITD_CHAR_BITS'(digs[i]),
                                          last: (i == 0)});
        endfunction

        function void check_char(input logic [7:0] data, input logic last);
            ascii_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, actual data %0d last %0b",
                         $time, data, last);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (data !== {2'b00, want.code})
            begin
                $display("%0t: char mismatch: expected %0d, actual %0d",
                         $time, {2'b00, want.code}, data);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for signed_int_to_decimal_ascii_unit: drives integers,
// checks each emitted character. Depends on sitd_pkg and sitd_tb_pkg.
module tb_top;

    import sitd_pkg::*;
    import sitd_tb_pkg::*;

    localparam int  HOLD_CYCLES  = 600;
    localparam int  DRAIN_CYCLES = 150;
    localparam time RUN_LIMIT    = 20_000_000ns;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;

    decimal_text_checker board = new();

    signed_int_to_decimal_ascii_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #10ns clk = ~clk;
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL signed_int_to_decimal_ascii_unit");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_char(m_axis_tdata, m_axis_tlast);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rst_n)
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_value(input logic [63:0] value);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.add_value(value);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        int          sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3:
                v = {$urandom, $urandom};
            4, 5:
                v = {$urandom, $urandom} >> $urandom_range(63);
            6:
            begin
                p = 64'd1;
                k = $urandom_range(18);
                repeat (k) p = p * 64'd10;
                v = p + 64'($urandom_range(2)) - 64'd1;
            end
            7:
                v = 64'($urandom_range(20));
            default:
                v = ($urandom_range(1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000)
                    ^ 64'($urandom_range(3));
        endcase
        if (sel >= 4 && sel <= 7 && $urandom_range(1))
            v = ~v + 64'd1;
        return v;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_value(pick_value());
    endtask

    initial
    begin
        logic [63:0] directed[$];
        directed = '{
            64'd0, 64'd1, 64'hffff_ffff_ffff_ffff, 64'd9, 64'd10, -64'sd10,
            64'd99, 64'd100, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe,
            64'd1000000000000000000, 64'd999999999999999999,
            -64'sd1000000000000000000, 64'd1234567890123456789,
            -64'sd1234567890123456789, 64'h5555_5555_5555_5555,
            64'haaaa_aaaa_aaaa_aaaa, 64'd1000000000, -64'sd9
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i]);

        hold_request = 1'b1;
        send_random(24);

        send_random(70);
        tx_idle_pct  = 64;
        send_random(80);
        tx_idle_pct  = 0;
        rx_stall_pct = 64;
        send_random(80);
        tx_idle_pct  = 8;
        rx_stall_pct = 8;
        send_random(76);

        s_axis_tvalid <= 1'b0;
        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("PASS signed_int_to_decimal_ascii_unit");
        else
            $display("FAIL signed_int_to_decimal_ascii_unit");
        $finish;
    end

endmodule
